// File: hw/rtl/rwl_pkg.sv
`default_nettype none
package rwl_pkg;

    localparam int THREAD_BITS = 8;
    localparam int COUNT_BITS  = 16;

    localparam logic [2:0] ACT_READ_LOCK    = 3'd0;
    localparam logic [2:0] ACT_TRY_READ     = 3'd1;
    localparam logic [2:0] ACT_WRITE_LOCK   = 3'd2;
    localparam logic [2:0] ACT_TRY_WRITE    = 3'd3;
    localparam logic [2:0] ACT_READ_UNLOCK  = 3'd4;
    localparam logic [2:0] ACT_WRITE_UNLOCK = 3'd5;
    localparam logic [2:0] ACT_CANCEL_WAIT  = 3'd6;

    localparam logic [3:0] ST_GRANTED     = 4'd0;
    localparam logic [3:0] ST_QUEUED      = 4'd1;
    localparam logic [3:0] ST_BUSY        = 4'd2;
    localparam logic [3:0] ST_UNLOCK_ERR  = 4'd3;
    localparam logic [3:0] ST_NO_ROOM     = 4'd4;
    localparam logic [3:0] ST_WOKEN       = 4'd5;
    localparam logic [3:0] ST_RELEASED    = 4'd6;
    localparam logic [3:0] ST_CANCELLED   = 4'd7;
    localparam logic [3:0] ST_NOT_WAITING = 4'd8;

    typedef struct packed {
        logic [2:0]             action;
        logic [THREAD_BITS-1:0] requester;
    } req_t;

    typedef struct packed {
        logic [3:0]             status;
        logic [THREAD_BITS-1:0] result_thread;
        logic                   as_writer;
        logic [COUNT_BITS-1:0]  reader_total;
        logic                   last;
    } rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/reader_writer_lock_fifo_arbiter_core.sv
// A lone result is formed in a pending register and then moved to the output register;
// with wake-ups each result is presented once the next one is formed.
// Lock, try and unlock without wake-up pass through the execute and flush states; a new request is taken only in idle.
// A release or cancel that serves the queue steps through the read and serve states per woken waiter.
// Cancel walks the queue memory: it searches entry by entry, then shifts each later entry down.
// Reset clears the lock registers and the waiter count; queue memory is not cleared.
`default_nettype none
module reader_writer_lock_fifo_arbiter_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire rwl_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output rwl_pkg::rsp_t      rsp
);
    import rwl_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = THREAD_BITS + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_SRD   = 3'd4;
    localparam logic [2:0] S_SERV  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;

    logic [2:0]             state_reg, state_next;
    logic [2:0]             act_reg, act_next;
    logic [THREAD_BITS-1:0] tid_reg, tid_next;
    logic [COUNT_BITS-1:0]  rc_reg, rc_next;
    logic                   wh_reg, wh_next;
    logic [THREAD_BITS-1:0] wt_reg, wt_next;
    logic [COUNT_BITS-1:0]  wd_reg, wd_next;
    logic [IW-1:0]          head_reg, head_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   cw_reg, cw_next;
    logic                   pend_valid_reg, pend_valid_next;
    rsp_t                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    rsp_t                   out_reg, out_next;

    logic                   out_free, can_put, do_put;
    rsp_t                   put_val;
    logic                   blocking, rd_ok;
    logic [EW-1:0]          entry;

    function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(k);
        if (s >= (CW+1)'(QUEUE_DEPTH))
            s = s - (CW+1)'(QUEUE_DEPTH);
        if (s >= (CW+1)'(QUEUE_DEPTH))
            s = s - (CW+1)'(QUEUE_DEPTH);
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] head_inc(input logic [IW-1:0] h);
        if (h == IW'(QUEUE_DEPTH - 1))
            return '0;
        return h + 1'b1;
    endfunction

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign can_put   = !pend_valid_reg || out_free;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign entry     = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        tid_next        = tid_reg;
        rc_next         = rc_reg;
        wh_next         = wh_reg;
        wt_next         = wt_reg;
        wd_next         = wd_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        cw_next         = cw_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_wa          = phys(head_reg, cnt_reg);
        mem_wd          = {1'b0, tid_reg};
        rd_addr         = phys(head_reg, '0);
        do_put          = 1'b0;
        put_val         = '0;
        blocking        = 1'b0;
        rd_ok           = 1'b0;

        if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next   = req.action;
                    tid_next   = req.requester;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                put_val.result_thread = tid_reg;
                put_val.reader_total  = rc_reg;
                if (can_put)
                begin
                    state_next = S_FLUSH;
                    case (act_reg)
                        ACT_READ_LOCK, ACT_TRY_READ:
                        begin
                            do_put   = 1'b1;
                            blocking = (act_reg == ACT_READ_LOCK);
                            if (cnt_reg == '0 && !(wh_reg && wt_reg != tid_reg))
                            begin
                                if (rc_reg == CMAX)
                                    put_val.status = ST_NO_ROOM;
                                else
                                begin
                                    rc_next              = rc_reg + 1'b1;
                                    put_val.status       = ST_GRANTED;
                                    put_val.reader_total = rc_reg + 1'b1;
                                end
                            end
                            else if (blocking)
                            begin
                                if (cnt_reg >= DEPTH_C)
                                    put_val.status = ST_NO_ROOM;
                                else
                                begin
                                    mem_we         = 1'b1;
                                    cnt_next       = cnt_reg + 1'b1;
                                    put_val.status = ST_QUEUED;
                                end
                            end
                            else
                                put_val.status = ST_BUSY;
                        end
                        ACT_WRITE_LOCK, ACT_TRY_WRITE:
                        begin
                            do_put            = 1'b1;
                            put_val.as_writer = 1'b1;
                            blocking          = (act_reg == ACT_WRITE_LOCK);
                            if (wh_reg && wt_reg == tid_reg)
                            begin
                                if (wd_reg == CMAX)
                                    put_val.status = ST_NO_ROOM;
                                else
                                begin
                                    wd_next        = wd_reg + 1'b1;
                                    put_val.status = ST_GRANTED;
                                end
                            end
                            else if (!wh_reg && rc_reg == '0 && cnt_reg == '0)
                            begin
                                wh_next        = 1'b1;
                                wt_next        = tid_reg;
                                wd_next        = COUNT_BITS'(1);
                                put_val.status = ST_GRANTED;
                            end
                            else if (blocking)
                            begin
                                if (cnt_reg >= DEPTH_C)
                                    put_val.status = ST_NO_ROOM;
                                else
                                begin
                                    mem_we         = 1'b1;
                                    mem_wd         = {1'b1, tid_reg};
                                    cnt_next       = cnt_reg + 1'b1;
                                    put_val.status = ST_QUEUED;
                                end
                            end
                            else
                                put_val.status = ST_BUSY;
                        end
                        ACT_READ_UNLOCK:
                        begin
                            do_put = 1'b1;
                            if (rc_reg == '0)
                                put_val.status = ST_UNLOCK_ERR;
                            else
                            begin
                                rc_next              = rc_reg - 1'b1;
                                put_val.status       = ST_RELEASED;
                                put_val.reader_total = rc_reg - 1'b1;
                                if (rc_reg == COUNT_BITS'(1))
                                    state_next = S_SRD;
                            end
                        end
                        ACT_WRITE_UNLOCK:
                        begin
                            do_put            = 1'b1;
                            put_val.as_writer = 1'b1;
                            if (!wh_reg || wt_reg != tid_reg)
                                put_val.status = ST_UNLOCK_ERR;
                            else
                            begin
                                put_val.status = ST_RELEASED;
                                if (wd_reg > COUNT_BITS'(1))
                                    wd_next = wd_reg - 1'b1;
                                else
                                begin
                                    wd_next    = '0;
                                    wh_next    = 1'b0;
                                    wt_next    = '0;
                                    state_next = S_SRD;
                                end
                            end
                        end
                        ACT_CANCEL_WAIT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                do_put         = 1'b1;
                                put_val.status = ST_NOT_WAITING;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_FLUSH;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                rd_addr               = phys(head_reg, idx_reg + 1'b1);
                put_val.result_thread = tid_reg;
                put_val.reader_total  = rc_reg;
                put_val.status        = ST_NOT_WAITING;
                if (entry[THREAD_BITS-1:0] == tid_reg)
                begin
                    cw_next    = entry[THREAD_BITS];
                    state_next = S_SHIFT;
                end
                else if (idx_reg + 1'b1 >= cnt_reg)
                begin
                    if (can_put)
                    begin
                        do_put     = 1'b1;
                        state_next = S_FLUSH;
                    end
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_SHIFT:
            begin
                rd_addr               = phys(head_reg, idx_reg + 2'd2);
                put_val.result_thread = tid_reg;
                put_val.reader_total  = rc_reg;
                put_val.status        = ST_CANCELLED;
                put_val.as_writer     = cw_reg;
                if (idx_reg + 1'b1 < cnt_reg)
                begin
                    mem_we   = 1'b1;
                    mem_wa   = phys(head_reg, idx_reg);
                    mem_wd   = entry;
                    idx_next = idx_reg + 1'b1;
                end
                else if (can_put)
                begin
                    do_put     = 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                state_next = S_SERV;
            end
            S_SERV:
            begin
                put_val.status        = ST_WOKEN;
                put_val.result_thread = entry[THREAD_BITS-1:0];
                put_val.as_writer     = entry[THREAD_BITS];
                put_val.reader_total  = rc_reg;
                rd_ok                 = (cnt_reg != '0) && !wh_reg;
                if (!rd_ok)
                    state_next = S_FLUSH;
                else if (entry[THREAD_BITS])
                begin
                    if (rc_reg != '0)
                        state_next = S_FLUSH;
                    else if (can_put)
                    begin
                        do_put     = 1'b1;
                        head_next  = head_inc(head_reg);
                        cnt_next   = cnt_reg - 1'b1;
                        wh_next    = 1'b1;
                        wt_next    = entry[THREAD_BITS-1:0];
                        wd_next    = COUNT_BITS'(1);
                        state_next = S_FLUSH;
                    end
                end
                else if (rc_reg == CMAX)
                    state_next = S_FLUSH;
                else if (can_put)
                begin
                    do_put               = 1'b1;
                    head_next            = head_inc(head_reg);
                    cnt_next             = cnt_reg - 1'b1;
                    rc_next              = rc_reg + 1'b1;
                    put_val.reader_total = rc_reg + 1'b1;
                    state_next           = S_SRD;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_put)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_next.last  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = put_val;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rc_reg         <= '0;
            wh_reg         <= 1'b0;
            wt_reg         <= '0;
            wd_reg         <= '0;
            head_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rc_reg         <= rc_next;
            wh_reg         <= wh_next;
            wt_reg         <= wt_next;
            wd_reg         <= wd_next;
            head_reg       <= head_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        tid_reg  <= tid_next;
        idx_reg  <= idx_next;
        cw_reg   <= cw_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("waiter count beyond queue depth");
    a_held_depth: assert property (@(posedge clk) disable iff (!rst_n)
        wh_reg |-> (wd_reg != '0))
        else $error("write lock held with zero depth");
    a_free_depth: assert property (@(posedge clk) disable iff (!rst_n)
        !wh_reg |-> (wd_reg == '0))
        else $error("write depth left on a free lock");
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("result held back after request finished");
`endif

endmodule
`default_nettype wire

// File: test/rwl_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module rwl_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_stall,
    input  wire rwl_pkg::req_t req,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_stall,
    input  wire rwl_pkg::rsp_t rsp,
    output int                 fail_count,
    output int                 pending
);
    import rwl_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    logic [COUNT_BITS-1:0]  readers;
    logic                   writer_on;
    logic [THREAD_BITS-1:0] writer_id;
    logic [COUNT_BITS-1:0]  writer_nest;
    logic [THREAD_BITS:0]   waiters[$];
    rsp_t                   expected_rsp[$];
    int                     first_new;

    assign pending = expected_rsp.size();

    function automatic void push_rsp(logic [3:0] st, logic [THREAD_BITS-1:0] tid, logic w);
        rsp_t r;
        r.status        = st;
        r.result_thread = tid;
        r.as_writer     = w;
        r.reader_total  = readers;
        r.last          = 1'b0;
        expected_rsp.push_back(r);
    endfunction

    function automatic void wake_head();
        logic [THREAD_BITS:0] head;
        if (waiters.size() == 0 || writer_on)
            return;
        head = waiters[0];
        if (head[THREAD_BITS]) begin
            if (readers == 0) begin
                void'(waiters.pop_front());
                writer_on   = 1'b1;
                writer_id   = head[THREAD_BITS-1:0];
                writer_nest = COUNT_BITS'(1);
                push_rsp(ST_WOKEN, head[THREAD_BITS-1:0], 1'b1);
            end
            return;
        end
        while (waiters.size() > 0 && !waiters[0][THREAD_BITS] && readers < COUNT_TOP) begin
            head = waiters.pop_front();
            readers++;
            push_rsp(ST_WOKEN, head[THREAD_BITS-1:0], 1'b0);
        end
    endfunction

    function automatic void add_waiter(logic [THREAD_BITS-1:0] tid, logic w);
        if (waiters.size() >= QUEUE_DEPTH) begin
            push_rsp(ST_NO_ROOM, tid, w);
        end
        else begin
            waiters.push_back({w, tid});
            push_rsp(ST_QUEUED, tid, w);
        end
    endfunction

    function automatic void predict_lock(req_t r);
        int  pos;
        logic w;
        case (r.action)
            ACT_READ_LOCK, ACT_TRY_READ:
                if (waiters.size() == 0 && !(writer_on && writer_id != r.requester)) begin
                    if (readers >= COUNT_TOP)
                        push_rsp(ST_NO_ROOM, r.requester, 1'b0);
                    else
                    begin
                        readers++;
                        push_rsp(ST_GRANTED, r.requester, 1'b0);
                    end
                end
                else if (r.action == ACT_READ_LOCK)
                    add_waiter(r.requester, 1'b0);
                else
                    push_rsp(ST_BUSY, r.requester, 1'b0);
            ACT_WRITE_LOCK, ACT_TRY_WRITE:
                if (writer_on && writer_id == r.requester) begin
                    if (writer_nest >= COUNT_TOP)
                        push_rsp(ST_NO_ROOM, r.requester, 1'b1);
                    else
                    begin
                        writer_nest++;
                        push_rsp(ST_GRANTED, r.requester, 1'b1);
                    end
                end
                else if (!writer_on && readers == 0 && waiters.size() == 0) begin
                    writer_on   = 1'b1;
                    writer_id   = r.requester;
                    writer_nest = COUNT_BITS'(1);
                    push_rsp(ST_GRANTED, r.requester, 1'b1);
                end
                else if (r.action == ACT_WRITE_LOCK)
                    add_waiter(r.requester, 1'b1);
                else
                    push_rsp(ST_BUSY, r.requester, 1'b1);
            ACT_READ_UNLOCK:
                if (readers == 0)
                    push_rsp(ST_UNLOCK_ERR, r.requester, 1'b0);
                else
                begin
                    readers--;
                    push_rsp(ST_RELEASED, r.requester, 1'b0);
                    if (readers == 0)
                        wake_head();
                end
            ACT_WRITE_UNLOCK:
                if (!writer_on || writer_id != r.requester)
                    push_rsp(ST_UNLOCK_ERR, r.requester, 1'b1);
                else
                begin
                    if (writer_nest > 0)
                        writer_nest--;
                    push_rsp(ST_RELEASED, r.requester, 1'b1);
                    if (writer_nest == 0) begin
                        writer_on = 1'b0;
                        writer_id = '0;
                        wake_head();
                    end
                end
            ACT_CANCEL_WAIT:
            begin
                pos = -1;
                foreach (waiters[i])
                    if (pos < 0 && waiters[i][THREAD_BITS-1:0] == r.requester)
                        pos = i;
                if (pos < 0)
                    push_rsp(ST_NOT_WAITING, r.requester, 1'b0);
                else
                begin
                    w = waiters[pos][THREAD_BITS];
                    waiters.delete(pos);
                    push_rsp(ST_CANCELLED, r.requester, w);
                    wake_head();
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_t got;
        rsp_t want;
        if (!rst_n) begin
            readers     = '0;
            writer_on   = 1'b0;
            writer_id   = '0;
            writer_nest = '0;
            waiters.delete();
            expected_rsp.delete();
            fail_count  = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall) begin
                got = rsp;
                if (expected_rsp.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transfer: %p", got);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (req_valid && !req_stall) begin
                first_new = expected_rsp.size();
                predict_lock(req);
                if (expected_rsp.size() > first_new)
                    expected_rsp[expected_rsp.size()-1].last = 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: test/tb_reader_writer_lock_fifo_arbiter_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_reader_writer_lock_fifo_arbiter_core;
    import rwl_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    int   cycle = 0;
    bit   hold_off = 1'b0;

    always #5 clk = ~clk;

    reader_writer_lock_fifo_arbiter_core dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    rwl_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > 400000) begin
            $display("** reader_writer_lock_fifo_arbiter_core: FAILED **");
            $finish;
        end
    end

    int stall_mode = 0;
    always @(posedge clk) begin
        if (hold_off)
            rsp_stall <= 1'b1;
        else
        begin
            if ($urandom_range(0, 31) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 3) == 0);
                default: rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    task automatic send_lock(logic [2:0] act, logic [THREAD_BITS-1:0] tid, bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req.action <= act;
        req.requester <= tid;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [THREAD_BITS-1:0] pick_thread();
        if ($urandom_range(0, 7) == 0)
            return THREAD_BITS'($urandom);
        return THREAD_BITS'($urandom_range(0, 5));
    endfunction

    initial begin
        logic [2:0] act;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_lock(ACT_READ_UNLOCK, 8'h00, 0);
        send_lock(ACT_WRITE_UNLOCK, 8'hff, 0);
        send_lock(ACT_CANCEL_WAIT, 8'h55, 0);
        send_lock(3'd7, 8'haa, 0);
        send_lock(ACT_WRITE_LOCK, 8'hff, 0);
        send_lock(ACT_TRY_WRITE, 8'hff, 0);
        send_lock(ACT_READ_LOCK, 8'hff, 0);
        send_lock(ACT_TRY_READ, 8'h01, 0);
        send_lock(ACT_READ_LOCK, 8'h01, 0);
        send_lock(ACT_READ_LOCK, 8'h02, 0);
        send_lock(ACT_WRITE_LOCK, 8'h03, 0);
        send_lock(ACT_READ_LOCK, 8'h04, 0);
        send_lock(ACT_READ_LOCK, 8'h02, 0);
        send_lock(ACT_CANCEL_WAIT, 8'h02, 0);
        send_lock(ACT_WRITE_UNLOCK, 8'h00, 0);
        send_lock(ACT_WRITE_UNLOCK, 8'hff, 0);
        send_lock(ACT_WRITE_UNLOCK, 8'hff, 0);
        send_lock(ACT_CANCEL_WAIT, 8'h03, 0);
        send_lock(ACT_READ_UNLOCK, 8'h01, 0);
        send_lock(ACT_READ_UNLOCK, 8'h02, 0);
        send_lock(ACT_READ_UNLOCK, 8'h04, 0);
        send_lock(ACT_READ_UNLOCK, 8'hff, 0);
        drain();

        // fill the queue past its depth behind a writer while the output is held
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_lock(ACT_WRITE_LOCK, 8'h10, 0);
                for (int i = 0; i < 18; i++)
                    send_lock(ACT_READ_LOCK, 8'(8'h20 + i), 0);
            end
        join
        send_lock(ACT_WRITE_UNLOCK, 8'h10, 0);
        drain();
        for (int i = 0; i < 16; i++)
            send_lock(ACT_READ_UNLOCK, 8'(8'h20 + i), 0);
        drain();

        for (int n = 0; n < 35; n++) begin
            act = 3'($urandom_range(0, 7));
            send_lock(act, pick_thread(), 1);
        end
        drain();
        // try to release what is still held and to empty the queue with random unlocks and cancels
        for (int n = 0; n < 15; n++)
            send_lock(3'($urandom_range(4, 6)), pick_thread(), 1);
        drain();

        if (fail_count == 0)
            $display("** reader_writer_lock_fifo_arbiter_core: PASSED **");
        else
            $display("** reader_writer_lock_fifo_arbiter_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
hw/rtl/rwl_pkg.sv
hw/rtl/reader_writer_lock_fifo_arbiter_core.sv
test/rwl_checker.sv
test/tb_reader_writer_lock_fifo_arbiter_core.sv
